/* sv/cf_pkg.sv */
`timescale 1ns / 1ps
package cf_pkg;

  // Opcode encoding of the instruction set.
  localparam logic [5:0] OP_ADD  = 6'd0;
  localparam logic [5:0] OP_SUB  = 6'd1;
  localparam logic [5:0] OP_MUL  = 6'd2;
  localparam logic [5:0] OP_AND  = 6'd3;
  localparam logic [5:0] OP_OR   = 6'd4;
  localparam logic [5:0] OP_XOR  = 6'd5;
  localparam logic [5:0] OP_SHL  = 6'd6;
  localparam logic [5:0] OP_SHR  = 6'd7;
  localparam logic [5:0] OP_SAR  = 6'd8;
  localparam logic [5:0] OP_DIV  = 6'd9;
  localparam logic [5:0] OP_MOD  = 6'd10;
  localparam logic [5:0] OP_NEG  = 6'd11;
  localparam logic [5:0] OP_NOT  = 6'd12;
  localparam logic [5:0] OP_MOV  = 6'd13;
  localparam logic [5:0] OP_MOVI = 6'd14;

  // Which unit supplies the folded constant at the end of the pipeline.
  typedef enum logic [1:0] {
    SEL_DIRECT = 2'd0,
    SEL_MUL    = 2'd1,
    SEL_DIV    = 2'd2,
    SEL_MOD    = 2'd3
  } sel_t;

  // Rewritten instruction as it travels down the pipeline.
  typedef struct packed {
    logic [5:0]  op;
    logic        a_imm;
    logic [63:0] a_val;
    logic        b_imm;
    logic [63:0] b_val;
    logic        changed;
    sel_t        sel;
    logic        q_neg;
    logic        r_neg;
  } info_t;

endpackage

/* sv/cf_decode.sv */
`timescale 1ns / 1ps
module cf_decode #(
  parameter int W = 64
) (
  input  logic [5:0]   opcode,
  input  logic         a_is_imm,
  input  logic [63:0]  a_value,
  input  logic         b_is_imm,
  input  logic [63:0]  b_value,
  output cf_pkg::info_t info,
  output logic [W-1:0] mul_a,
  output logic [W-1:0] mul_b,
  output logic [W-1:0] dvd,
  output logic [W-1:0] dvs
);
  import cf_pkg::*;

  logic [W-1:0] na, nb, simple;
  logic [5:0]   amt;
  logic         fold_bin, fold_un, b_zero, b_one;

  assign na    = a_value[W-1:0];
  assign nb    = b_value[W-1:0];
  assign amt   = b_value[5:0];
  assign b_zero = (nb == '0);
  assign b_one  = (nb == W'(1));

  assign mul_a = na;
  assign mul_b = nb;
  // Magnitudes for the unsigned divider; the most negative value maps to itself.
  assign dvd   = na[W-1] ? (W'(0) - na) : na;
  assign dvs   = nb[W-1] ? (W'(0) - nb) : nb;

  // Operations that finish in this stage.
  always_comb begin
    case (opcode)
      OP_ADD:  simple = na + nb;
      OP_SUB:  simple = na - nb;
      OP_AND:  simple = na & nb;
      OP_OR:   simple = na | nb;
      OP_XOR:  simple = na ^ nb;
      OP_SHL:  simple = na << amt;
      OP_SHR:  simple = na >> amt;
      OP_SAR:  simple = W'($signed(na) >>> amt);
      OP_NEG:  simple = W'(0) - na;
      OP_NOT:  simple = ~na;
      default: simple = '0;
    endcase
  end

  always_comb begin
    case (opcode)
      OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR,
      OP_SHL, OP_SHR, OP_SAR:  fold_bin = a_is_imm & b_is_imm;
      OP_DIV, OP_MOD:          fold_bin = a_is_imm & b_is_imm & ~b_zero;
      default:                 fold_bin = 1'b0;
    endcase
  end

  assign fold_un = a_is_imm & ((opcode == OP_NEG) | (opcode == OP_NOT));

  // Rewrite decision, in priority order: binary fold, unary fold, identity.
  always_comb begin
    info.op      = opcode;
    info.a_imm   = a_is_imm;
    info.a_val   = a_value;
    info.b_imm   = b_is_imm;
    info.b_val   = b_value;
    info.changed = 1'b0;
    info.sel     = SEL_DIRECT;
    info.q_neg   = na[W-1] ^ nb[W-1];
    info.r_neg   = na[W-1];
    if (fold_bin || fold_un) begin
      info.op      = OP_MOVI;
      info.a_imm   = 1'b1;
      info.a_val   = 64'($signed(simple));
      info.changed = 1'b1;
      if (fold_bin && opcode == OP_MUL) begin
        info.sel = SEL_MUL;
      end else if (fold_bin && opcode == OP_DIV) begin
        info.sel = SEL_DIV;
      end else if (fold_bin && opcode == OP_MOD) begin
        info.sel = SEL_MOD;
      end
    end else if (!a_is_imm && b_is_imm) begin
      if ((opcode == OP_ADD && b_zero) || (opcode == OP_MUL && b_one)) begin
        info.op      = OP_MOV;
        info.changed = 1'b1;
      end else if ((opcode == OP_MUL || opcode == OP_AND) && b_zero) begin
        info.op      = OP_MOVI;
        info.a_imm   = 1'b1;
        info.a_val   = '0;
        info.changed = 1'b1;
      end
    end
    if (info.changed) begin
      info.b_imm = 1'b0;
      info.b_val = '0;
    end
  end

endmodule

/* sv/cf_mul.sv */
`timescale 1ns / 1ps
module cf_mul #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] prod
);
  localparam int HALF = (W + 1) / 2;
  localparam int HI   = W - HALF;

  logic [HALF-1:0]   a_lo, b_lo;
  logic [HI-1:0]     a_hi, b_hi;
  logic [2*HALF-1:0] p0;
  logic [HI-1:0]     c1, c2;

  assign a_lo = a[HALF-1:0];
  assign b_lo = b[HALF-1:0];
  assign a_hi = a[W-1:HALF];
  assign b_hi = b[W-1:HALF];

  // First stage: low product and the low bits of the two cross products.
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= (2*HALF)'(a_lo) * (2*HALF)'(b_lo);
      c1 <= HI'(a_lo * HALF'(b_hi));
      c2 <= HI'(HALF'(a_hi) * b_lo);
    end
  end

  // Second stage: combine into the wrapped W-bit product.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= p0[W-1:0] + {HI'(c1 + c2), {HALF{1'b0}}};
    end
  end

endmodule

/* sv/cf_div_step.sv */
`timescale 1ns / 1ps
module cf_div_step #(
  parameter int W = 64
) (
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] dq_in,
  input  logic [W-1:0] dvs,
  output logic [W-1:0] rem_out,
  output logic [W-1:0] dq_out
);
  logic [W:0] trial, diff;
  logic       ge;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign trial   = {rem_in, dq_in[W-1]};
  assign diff    = trial - {1'b0, dvs};
  assign ge      = (trial >= {1'b0, dvs});
  assign rem_out = ge ? diff[W-1:0] : trial[W-1:0];
  assign dq_out  = {dq_in[W-2:0], ge};

endmodule

/* sv/ir_constant_folder.sv */
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | opcode, a_is_imm, a_value, b_is_imm, b_value
// output   | out_valid / out_ready| out_opcode, out_a_is_imm, out_a_value,
//          |                      | out_b_is_imm, out_b_value, changed
// One instruction is taken per cycle while the output is not stalled; each
// result passes stage zero, the divider chain and the output stage in order.
// All stages advance together; when the output holds a result that is not
// taken, the whole pipeline and in_ready stall, so nothing is lost or repeated.
// Synchronous reset clears the valid bits only.
module ir_constant_folder #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  opcode,
  input  logic        a_is_imm,
  input  logic [63:0] a_value,
  input  logic        b_is_imm,
  input  logic [63:0] b_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_opcode,
  output logic        out_a_is_imm,
  output logic [63:0] out_a_value,
  output logic        out_b_is_imm,
  output logic [63:0] out_b_value,
  output logic        changed
);
  import cf_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int LAST = W + 1;

  logic                adv;
  logic [LAST:0]       vld;
  info_t               meta [0:LAST];
  logic [W-1:0]        rem  [0:W];
  logic [W-1:0]        dq   [0:W];
  logic [W-1:0]        dvs  [0:W];
  logic [W-1:0]        opa, opb, prod;
  info_t               dec_info;
  logic [W-1:0]        dec_a, dec_b, dec_dvd, dec_dvs;

  assign adv      = ~vld[LAST] | out_ready;
  assign in_ready = adv;

  cf_decode #(.W(W)) u_decode (
    .opcode   (opcode),
    .a_is_imm (a_is_imm),
    .a_value  (a_value),
    .b_is_imm (b_is_imm),
    .b_value  (b_value),
    .info     (dec_info),
    .mul_a    (dec_a),
    .mul_b    (dec_b),
    .dvd      (dec_dvd),
    .dvs      (dec_dvs)
  );

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  // Stage zero: decoded instruction and unit operands.
  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0] <= dec_info;
      opa     <= dec_a;
      opb     <= dec_b;
      rem[0]  <= '0;
      dq[0]   <= dec_dvd;
      dvs[0]  <= dec_dvs;
    end
  end

  cf_mul #(.W(W)) u_mul (
    .clk  (clk),
    .en   (adv),
    .a    (opa),
    .b    (opb),
    .prod (prod)
  );

  // Divider chain, one quotient bit per stage.
  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [W-1:0] rem_n, dq_n;

    cf_div_step #(.W(W)) u_step (
      .rem_in  (rem[k-1]),
      .dq_in   (dq[k-1]),
      .dvs     (dvs[k-1]),
      .rem_out (rem_n),
      .dq_out  (dq_n)
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= rem_n;
        dq[k]  <= dq_n;
        dvs[k] <= dvs[k-1];
      end
    end
  end

  // Instruction fields travel alongside; the product joins at stage three.
  for (genvar k = 1; k < LAST; k++) begin : g_meta
    info_t meta_next;

    always_comb begin
      meta_next = meta[k-1];
      if (k == 3 && meta[k-1].sel == SEL_MUL) begin
        meta_next.a_val = 64'($signed(prod));
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        meta[k] <= meta_next;
      end
    end
  end

  // Output stage: apply the signs to quotient or remainder.
  logic [W-1:0] q_fix, r_fix;
  info_t        last_next;

  assign q_fix = meta[W].q_neg ? (W'(0) - dq[W]) : dq[W];
  assign r_fix = meta[W].r_neg ? (W'(0) - rem[W]) : rem[W];

  always_comb begin
    last_next = meta[W];
    case (meta[W].sel)
      SEL_DIV: last_next.a_val = 64'($signed(q_fix));
      SEL_MOD: last_next.a_val = 64'($signed(r_fix));
      default: last_next.a_val = meta[W].a_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta[LAST] <= last_next;
    end
  end

  assign out_valid    = vld[LAST];
  assign out_opcode   = meta[LAST].op;
  assign out_a_is_imm = meta[LAST].a_imm;
  assign out_a_value  = meta[LAST].a_val;
  assign out_b_is_imm = meta[LAST].b_imm;
  assign out_b_value  = meta[LAST].b_val;
  assign changed      = meta[LAST].changed;

endmodule

/* sv/cf_checker.sv */
`timescale 1ns / 1ps
module cf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_opcode,
  input logic        out_a_is_imm,
  input logic [63:0] out_a_value,
  input logic        out_b_is_imm,
  input logic [63:0] out_b_value,
  input logic        changed
);
  import cf_pkg::*;

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_a_value))
    else $error("output changed while stalled");

  // A stalled output stalls the input side too.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  // Every rewrite clears the second operand.
  a_clear_b: assert property (@(posedge clk) disable iff (rst)
    out_valid && changed |-> !out_b_is_imm && out_b_value == 64'd0)
    else $error("rewritten instruction kept its second operand");

  // Rewrites produce only mov or movi, and movi carries an immediate.
  a_rewrite_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && changed |-> (out_opcode == OP_MOV) ||
                             (out_opcode == OP_MOVI && out_a_is_imm))
    else $error("bad rewritten opcode");

endmodule

bind ir_constant_folder cf_checker u_cf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_opcode   (out_opcode),
  .out_a_is_imm (out_a_is_imm),
  .out_a_value  (out_a_value),
  .out_b_is_imm (out_b_is_imm),
  .out_b_value  (out_b_value),
  .changed      (changed)
);
